FILE: hdl/tmswm_pkg.sv
package tmswm_pkg;

   // Group length and derived accumulator widths
   localparam int SAMPLES   = 10;
   localparam int SAMPLE_W  = 10;
   localparam int CHANNEL_W = 3;
   localparam int COUNT_W   = $clog2(SAMPLES);
   localparam int SUM_W     = $clog2(SAMPLES * 1023 + 1);

   // Trimmed mean divides by SAMPLES-2 through a rounded-up reciprocal.
   // With SHIFT = SUM_W + ceil(log2(DIVISOR)) the quotient is exact for
   // every dividend below 2**SUM_W.
   localparam int DIVISOR  = SAMPLES - 2;
   localparam int DIV_LOG  = $clog2(DIVISOR);
   localparam int SHIFT    = SUM_W + DIV_LOG;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam int RECIP_W  = SHIFT + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;

   // Scaling to units of 1/1024
   localparam int TEMP_W      = 19;
   localparam int CURR_W      = 16;
   localparam int SCALED_W    = 20;
   localparam int CMP_W       = 21;
   localparam int TEMP_GAIN   = 500;
   localparam int CURR_GAIN   = 50;
   localparam int CURR_OFFSET = 25600;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 19;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_FAULT_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_FAULT_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_WARN_LOW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_WARN_HIGH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CURR_FAULT_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CURR_FAULT_HIGH = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CURR_WARN_LOW   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_CURR_WARN_HIGH  = 3'd7;

   // Threshold reset values
   localparam logic [TEMP_W-1:0]        TEMP_LOW_RST  = 19'd0;
   localparam logic [TEMP_W-1:0]        TEMP_HIGH_RST = 19'd511500;
   localparam logic signed [CURR_W-1:0] CURR_LOW_RST  = -16'sd25600;
   localparam logic signed [CURR_W-1:0] CURR_HIGH_RST = 16'sd25550;

   // Status codes
   localparam logic [1:0] STATUS_FAULT  = 2'd0;
   localparam logic [1:0] STATUS_WARN   = 2'd1;
   localparam logic [1:0] STATUS_NORMAL = 2'd2;

   // Group queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [SUM_W-1:0]     sum;
      logic [SAMPLE_W-1:0]  min;
      logic [SAMPLE_W-1:0]  max;
      logic                 kind;
      logic [CHANNEL_W-1:0] channel;
   } group_type;

   typedef struct packed {
      logic [TEMP_W-1:0]        temp_fault_low;
      logic [TEMP_W-1:0]        temp_fault_high;
      logic [TEMP_W-1:0]        temp_warn_low;
      logic [TEMP_W-1:0]        temp_warn_high;
      logic signed [CURR_W-1:0] curr_fault_low;
      logic signed [CURR_W-1:0] curr_fault_high;
      logic signed [CURR_W-1:0] curr_warn_low;
      logic signed [CURR_W-1:0] curr_warn_high;
   } thresh_type;

endpackage

FILE: hdl/tmswm_front.sv
module tmswm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tmswm_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                              req_kind,
   input  logic [tmswm_pkg::CHANNEL_W-1:0]   req_channel,
   input  logic                              q_full,
   output logic                              q_push,
   output tmswm_pkg::group_type              q_data
);

   logic [tmswm_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [tmswm_pkg::SUM_W-1:0]    sum_ff, sum_in, sum_next;
   logic [tmswm_pkg::SAMPLE_W-1:0] min_ff, min_in, min_next;
   logic [tmswm_pkg::SAMPLE_W-1:0] max_ff, max_in, max_next;
   logic                           accept;
   logic                           last;

   // Hold the input while the queue has no room
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign last      = (count_ff == tmswm_pkg::COUNT_W'(tmswm_pkg::SAMPLES - 1));

   // Fold the new sample into the group statistics
   assign sum_next = sum_ff + tmswm_pkg::SUM_W'(req_sample);
   assign min_next = (req_sample < min_ff) ? req_sample : min_ff;
   assign max_next = (req_sample > max_ff) ? req_sample : max_ff;

   // Hand a finished group to the back end
   assign q_push         = accept && last;
   assign q_data.sum     = sum_next;
   assign q_data.min     = min_next;
   assign q_data.max     = max_next;
   assign q_data.kind    = req_kind;
   assign q_data.channel = req_channel;

   // Advance or restart the group
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (accept) begin
         if (last) begin
            count_in = '0;
            sum_in   = '0;
            min_in   = '1;
            max_in   = '0;
         end else begin
            count_in = count_ff + tmswm_pkg::COUNT_W'(1);
            sum_in   = sum_next;
            min_in   = min_next;
            max_in   = max_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

endmodule

FILE: hdl/tmswm_queue.sv
module tmswm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tmswm_pkg::group_type push_data,
   input  logic                 pop,
   output tmswm_pkg::group_type head,
   output logic                 empty,
   output logic                 full
);

   tmswm_pkg::group_type              entry_ff [tmswm_pkg::QUEUE_DEPTH];
   logic [tmswm_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [tmswm_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == tmswm_pkg::QCNT_W'(tmswm_pkg::QUEUE_DEPTH));

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + tmswm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tmswm_pkg::QCNT_W'(1);
      end
   end

   // Store pushed groups
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + tmswm_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + tmswm_pkg::QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/tmswm_back.sv
module tmswm_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tmswm_pkg::thresh_type                 thresh,
   input  logic                                  q_empty,
   input  tmswm_pkg::group_type                  q_head,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tmswm_pkg::CHANNEL_W-1:0]       rsp_channel_tag,
   output logic                                  rsp_kind_tag,
   output logic [tmswm_pkg::SAMPLE_W-1:0]        rsp_average,
   output logic signed [tmswm_pkg::SCALED_W-1:0] rsp_scaled_value,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_relay_open,
   output logic                                  rsp_critical_on,
   output logic                                  rsp_warning_on
);

   logic advance;

   // Stage 1: trimmed sum
   logic                              s1_valid_ff;
   logic [tmswm_pkg::SUM_W-1:0]       s1_trim_ff, s1_trim_in;
   logic                              s1_kind_ff;
   logic [tmswm_pkg::CHANNEL_W-1:0]   s1_chan_ff;

   // Stage 2: average
   logic                              s2_valid_ff;
   logic [tmswm_pkg::PROD_W-1:0]      s2_prod;
   logic [tmswm_pkg::SAMPLE_W-1:0]    s2_avg_ff, s2_avg_in;
   logic                              s2_kind_ff;
   logic [tmswm_pkg::CHANNEL_W-1:0]   s2_chan_ff;

   // Stage 3: scaled value
   logic                                  s3_valid_ff;
   logic [tmswm_pkg::TEMP_W-1:0]          s3_temp;
   logic [tmswm_pkg::CURR_W-1:0]          s3_curr_mag;
   logic signed [tmswm_pkg::SCALED_W-1:0] s3_curr;
   logic signed [tmswm_pkg::SCALED_W-1:0] s3_val_ff, s3_val_in;
   logic [tmswm_pkg::SAMPLE_W-1:0]        s3_avg_ff;
   logic                                  s3_kind_ff;
   logic [tmswm_pkg::CHANNEL_W-1:0]       s3_chan_ff;

   // Classification
   logic signed [tmswm_pkg::CMP_W-1:0] val_ext;
   logic signed [tmswm_pkg::CMP_W-1:0] fault_lo, fault_hi, warn_lo, warn_hi;
   logic                               fault, warn;
   logic [1:0]                         status_in;

   // Output register and latched flags
   logic                                  out_valid_ff;
   logic [tmswm_pkg::CHANNEL_W-1:0]       out_chan_ff;
   logic                                  out_kind_ff;
   logic [tmswm_pkg::SAMPLE_W-1:0]        out_avg_ff;
   logic signed [tmswm_pkg::SCALED_W-1:0] out_val_ff;
   logic [1:0]                            out_status_ff;
   logic                                  relay_ff, critical_ff, warning_ff;
   logic                                  relay_in, critical_in, warning_in;

   // Move the whole pipe whenever the output register is free or taken
   assign advance = !out_valid_ff || !rsp_stall;
   assign q_pop   = advance && !q_empty;

   // Drop min and max from the sum
   assign s1_trim_in = q_head.sum
                     - tmswm_pkg::SUM_W'(q_head.min)
                     - tmswm_pkg::SUM_W'(q_head.max);

   // Divide by the trimmed group size with the reciprocal
   assign s2_prod   = tmswm_pkg::PROD_W'(s1_trim_ff)
                    * tmswm_pkg::PROD_W'(tmswm_pkg::RECIP);
   assign s2_avg_in = s2_prod[tmswm_pkg::SHIFT +: tmswm_pkg::SAMPLE_W];

   // Scale to temperature or current
   assign s3_temp     = tmswm_pkg::TEMP_W'(s2_avg_ff)
                      * tmswm_pkg::TEMP_W'(tmswm_pkg::TEMP_GAIN);
   assign s3_curr_mag = tmswm_pkg::CURR_W'(s2_avg_ff)
                      * tmswm_pkg::CURR_W'(tmswm_pkg::CURR_GAIN);
   assign s3_curr     = $signed(tmswm_pkg::SCALED_W'(s3_curr_mag))
                      - $signed(tmswm_pkg::SCALED_W'(tmswm_pkg::CURR_OFFSET));
   assign s3_val_in   = s2_kind_ff ? s3_curr
                                   : $signed(tmswm_pkg::SCALED_W'(s3_temp));

   // Pick the windows of the group's kind
   assign val_ext = tmswm_pkg::CMP_W'(s3_val_ff);
   always_comb begin
      if (s3_kind_ff) begin
         fault_lo = tmswm_pkg::CMP_W'(thresh.curr_fault_low);
         fault_hi = tmswm_pkg::CMP_W'(thresh.curr_fault_high);
         warn_lo  = tmswm_pkg::CMP_W'(thresh.curr_warn_low);
         warn_hi  = tmswm_pkg::CMP_W'(thresh.curr_warn_high);
      end else begin
         fault_lo = $signed({2'b00, thresh.temp_fault_low});
         fault_hi = $signed({2'b00, thresh.temp_fault_high});
         warn_lo  = $signed({2'b00, thresh.temp_warn_low});
         warn_hi  = $signed({2'b00, thresh.temp_warn_high});
      end
   end

   // Classify and latch the flags
   assign fault = (val_ext < fault_lo) || (val_ext > fault_hi);
   assign warn  = (val_ext <= warn_lo) || (val_ext >= warn_hi);

   always_comb begin
      relay_in    = relay_ff;
      critical_in = critical_ff;
      warning_in  = warning_ff;
      status_in   = tmswm_pkg::STATUS_NORMAL;
      if (fault) begin
         status_in   = tmswm_pkg::STATUS_FAULT;
         relay_in    = 1'b1;
         critical_in = 1'b1;
         warning_in  = 1'b1;
      end else if (warn) begin
         status_in  = tmswm_pkg::STATUS_WARN;
         warning_in = 1'b1;
      end
   end

   // Stage valids and latched flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         relay_ff     <= 1'b0;
         critical_ff  <= 1'b0;
         warning_ff   <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
         if (s3_valid_ff) begin
            relay_ff    <= relay_in;
            critical_ff <= critical_in;
            warning_ff  <= warning_in;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_trim_ff    <= s1_trim_in;
         s1_kind_ff    <= q_head.kind;
         s1_chan_ff    <= q_head.channel;
         s2_avg_ff     <= s2_avg_in;
         s2_kind_ff    <= s1_kind_ff;
         s2_chan_ff    <= s1_chan_ff;
         s3_val_ff     <= s3_val_in;
         s3_avg_ff     <= s2_avg_ff;
         s3_kind_ff    <= s2_kind_ff;
         s3_chan_ff    <= s2_chan_ff;
         out_chan_ff   <= s3_chan_ff;
         out_kind_ff   <= s3_kind_ff;
         out_avg_ff    <= s3_avg_ff;
         out_val_ff    <= s3_val_ff;
         out_status_ff <= status_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_channel_tag  = out_chan_ff;
   assign rsp_kind_tag     = out_kind_ff;
   assign rsp_average      = out_avg_ff;
   assign rsp_scaled_value = out_val_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_relay_open   = relay_ff;
   assign rsp_critical_on  = critical_ff;
   assign rsp_warning_on   = warning_ff;

endmodule

FILE: hdl/trimmed_mean_sensor_window_monitor.sv
// A group's last sample enters the queue, then the s1, s2, s3 and out registers,
// the last driving rsp_valid; the result leaves at the next edge with rsp_stall low.
// Throughput: one sample per cycle if req_stall is low; one result per SAMPLES samples.
// The back end runs a 4-stage pipe (trim, reciprocal divide, scale, classify) behind a
// 2-entry group queue, so it can take a group every cycle while rsp_stall is low.
// Reset (synchronous): clears group statistics, queue, pipe and latched flags,
// and returns all thresholds to their default windows.
module trimmed_mean_sensor_window_monitor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [tmswm_pkg::SAMPLE_W-1:0]        req_sample,
   input  logic                                  req_kind,
   input  logic [tmswm_pkg::CHANNEL_W-1:0]       req_channel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tmswm_pkg::CHANNEL_W-1:0]       rsp_channel_tag,
   output logic                                  rsp_kind_tag,
   output logic [tmswm_pkg::SAMPLE_W-1:0]        rsp_average,
   output logic signed [tmswm_pkg::SCALED_W-1:0] rsp_scaled_value,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_relay_open,
   output logic                                  rsp_critical_on,
   output logic                                  rsp_warning_on,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tmswm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tmswm_pkg::CSR_DATA_W-1:0]      csr_data
);

   tmswm_pkg::thresh_type thresh_ff, thresh_in;
   tmswm_pkg::group_type  q_data, q_head;
   logic                  q_push, q_pop, q_empty, q_full;
   logic                  csr_write;

   // Threshold registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_write) begin
         unique case (csr_index)
            tmswm_pkg::REG_TEMP_FAULT_LOW:  thresh_in.temp_fault_low  = csr_data;
            tmswm_pkg::REG_TEMP_FAULT_HIGH: thresh_in.temp_fault_high = csr_data;
            tmswm_pkg::REG_TEMP_WARN_LOW:   thresh_in.temp_warn_low   = csr_data;
            tmswm_pkg::REG_TEMP_WARN_HIGH:  thresh_in.temp_warn_high  = csr_data;
            tmswm_pkg::REG_CURR_FAULT_LOW:
               thresh_in.curr_fault_low  = $signed(csr_data[tmswm_pkg::CURR_W-1:0]);
            tmswm_pkg::REG_CURR_FAULT_HIGH:
               thresh_in.curr_fault_high = $signed(csr_data[tmswm_pkg::CURR_W-1:0]);
            tmswm_pkg::REG_CURR_WARN_LOW:
               thresh_in.curr_warn_low   = $signed(csr_data[tmswm_pkg::CURR_W-1:0]);
            tmswm_pkg::REG_CURR_WARN_HIGH:
               thresh_in.curr_warn_high  = $signed(csr_data[tmswm_pkg::CURR_W-1:0]);
            default: thresh_in = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.temp_fault_low  <= tmswm_pkg::TEMP_LOW_RST;
         thresh_ff.temp_fault_high <= tmswm_pkg::TEMP_HIGH_RST;
         thresh_ff.temp_warn_low   <= tmswm_pkg::TEMP_LOW_RST;
         thresh_ff.temp_warn_high  <= tmswm_pkg::TEMP_HIGH_RST;
         thresh_ff.curr_fault_low  <= tmswm_pkg::CURR_LOW_RST;
         thresh_ff.curr_fault_high <= tmswm_pkg::CURR_HIGH_RST;
         thresh_ff.curr_warn_low   <= tmswm_pkg::CURR_LOW_RST;
         thresh_ff.curr_warn_high  <= tmswm_pkg::CURR_HIGH_RST;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // Accumulate groups
   tmswm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .req_kind    (req_kind),
      .req_channel (req_channel),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   // Buffer finished groups
   tmswm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Average, scale and classify
   tmswm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .thresh           (thresh_ff),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel_tag  (rsp_channel_tag),
      .rsp_kind_tag     (rsp_kind_tag),
      .rsp_average      (rsp_average),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_status       (rsp_status),
      .rsp_relay_open   (rsp_relay_open),
      .rsp_critical_on  (rsp_critical_on),
      .rsp_warning_on   (rsp_warning_on)
   );

   // A fault item always carries the relay flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == tmswm_pkg::STATUS_FAULT) |-> rsp_relay_open)
      else $error("fault status without relay flag");

   // Relay flag implies the critical and warning flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_relay_open |-> rsp_critical_on && rsp_warning_on)
      else $error("relay flag without critical and warning flags");

   // Flags stay latched until reset
   assert property (@(posedge clock) disable iff (reset)
      rsp_relay_open |=> rsp_relay_open)
      else $error("relay flag dropped without reset");

   // Temperature value follows the reported average
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind_tag |->
         rsp_scaled_value == $signed({1'b0, tmswm_pkg::TEMP_W'(rsp_average)
                                           * tmswm_pkg::TEMP_W'(tmswm_pkg::TEMP_GAIN)}))
      else $error("temperature scaling mismatch");

endmodule

FILE: tb/sv/trimmed_mean_sensor_window_monitor_tb.sv
module trimmed_mean_sensor_window_monitor_tb;

   // Cycles with no handshake at all before the run is declared hung
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASES       = 9;
   localparam int PHASE_GROUPS = 10;
   localparam int DIR_ROWS     = 20;

   typedef struct packed {
      logic [tmswm_pkg::CHANNEL_W-1:0]       channel;
      logic                                  kind;
      logic [tmswm_pkg::SAMPLE_W-1:0]        average;
      logic signed [tmswm_pkg::SCALED_W-1:0] scaled;
      logic [1:0]                            status;
      logic                                  relay;
      logic                                  critical;
      logic                                  warning;
   } mean_result_type;

   typedef struct packed {
      logic [tmswm_pkg::SAMPLE_W-1:0]  sample;
      logic                            kind;
      logic [tmswm_pkg::CHANNEL_W-1:0] chan;
      logic                            typed;
      mean_result_type                 want;
   } dir_row_type;

   localparam mean_result_type NO_RES = '0;
   // All samples at full scale but one zero: trimming drops the zero
   localparam mean_result_type HOT_WARN = '{3'd7, 1'b0, 10'd1023, 20'sd511500,
                                            tmswm_pkg::STATUS_WARN, 1'b0, 1'b0, 1'b1};
   // All samples zero but one full scale, current just below the raised fault floor
   localparam mean_result_type COLD_FAULT = '{3'd0, 1'b1, 10'd0, -20'sd25600,
                                              tmswm_pkg::STATUS_FAULT, 1'b1, 1'b1, 1'b1};

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // temperature group at full scale, hits the inclusive warning edge
      '{10'd1023, 1'b0, 3'd0, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 3'd1, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 3'd2, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 3'd3, 1'b0, NO_RES},
      '{10'd0,    1'b0, 3'd4, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 3'd5, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 3'd6, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 3'd7, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 3'd0, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 3'd7, 1'b1, HOT_WARN},
      // mixed kinds, last one current: current scaling and windows apply
      '{10'd0,    1'b0, 3'd7, 1'b0, NO_RES},
      '{10'd0,    1'b1, 3'd6, 1'b0, NO_RES},
      '{10'd1023, 1'b0, 3'd5, 1'b0, NO_RES},
      '{10'd0,    1'b1, 3'd4, 1'b0, NO_RES},
      '{10'd0,    1'b0, 3'd3, 1'b0, NO_RES},
      '{10'd0,    1'b1, 3'd2, 1'b0, NO_RES},
      '{10'd0,    1'b0, 3'd1, 1'b0, NO_RES},
      '{10'd0,    1'b1, 3'd0, 1'b0, NO_RES},
      '{10'd0,    1'b0, 3'd3, 1'b0, NO_RES},
      '{10'd0,    1'b1, 3'd0, 1'b1, COLD_FAULT}
   };

   localparam logic [tmswm_pkg::CSR_INDEX_W-1:0] REG_ORDER [8] = '{
      tmswm_pkg::REG_TEMP_FAULT_LOW, tmswm_pkg::REG_TEMP_FAULT_HIGH,
      tmswm_pkg::REG_TEMP_WARN_LOW,  tmswm_pkg::REG_TEMP_WARN_HIGH,
      tmswm_pkg::REG_CURR_FAULT_LOW, tmswm_pkg::REG_CURR_FAULT_HIGH,
      tmswm_pkg::REG_CURR_WARN_LOW,  tmswm_pkg::REG_CURR_WARN_HIGH
   };

   logic                                  clock       = 1'b0;
   logic                                  reset       = 1'b1;
   logic                                  req_valid   = 1'b0;
   logic                                  req_stall;
   logic [tmswm_pkg::SAMPLE_W-1:0]        req_sample  = '0;
   logic                                  req_kind    = 1'b0;
   logic [tmswm_pkg::CHANNEL_W-1:0]       req_channel = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall   = 1'b0;
   logic [tmswm_pkg::CHANNEL_W-1:0]       rsp_channel_tag;
   logic                                  rsp_kind_tag;
   logic [tmswm_pkg::SAMPLE_W-1:0]        rsp_average;
   logic signed [tmswm_pkg::SCALED_W-1:0] rsp_scaled_value;
   logic [1:0]                            rsp_status;
   logic                                  rsp_relay_open;
   logic                                  rsp_critical_on;
   logic                                  rsp_warning_on;
   logic                                  csr_valid   = 1'b0;
   logic                                  csr_ready;
   logic [tmswm_pkg::CSR_INDEX_W-1:0]     csr_index   = '0;
   logic [tmswm_pkg::CSR_DATA_W-1:0]      csr_data    = '0;

   // Predictor copy of the window thresholds
   int t_fault_lo = 0;
   int t_fault_hi = 511500;
   int t_warn_lo  = 0;
   int t_warn_hi  = 511500;
   int c_fault_lo = -25600;
   int c_fault_hi = 25550;
   int c_warn_lo  = -25600;
   int c_warn_hi  = 25550;

   // Predictor copy of the group statistics and latched flags
   int   grp_count = 0;
   int   grp_sum   = 0;
   int   grp_min   = 1023;
   int   grp_max   = 0;
   logic relay_latch    = 1'b0;
   logic critical_latch = 1'b0;
   logic warning_latch  = 1'b0;

   mean_result_type pending_means[$];
   mean_result_type head_mean;
   int fail_count  = 0;
   int idle_cycles = 0;
   int gap_pct     = 7;
   int stall_pct   = 58;

   trimmed_mean_sensor_window_monitor u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_kind         (req_kind),
      .req_channel      (req_channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel_tag  (rsp_channel_tag),
      .rsp_kind_tag     (rsp_kind_tag),
      .rsp_average      (rsp_average),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_status       (rsp_status),
      .rsp_relay_open   (rsp_relay_open),
      .rsp_critical_on  (rsp_critical_on),
      .rsp_warning_on   (rsp_warning_on),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Accumulate one sample; on the last of a group, trim, scale and classify
   function automatic bit predict_window(input logic [tmswm_pkg::SAMPLE_W-1:0] s,
         input logic k, input logic [tmswm_pkg::CHANNEL_W-1:0] ch,
         output mean_result_type res);
      int avg, val, flo, fhi, wlo, whi;
      res = '0;
      grp_sum += int'(s);
      if (int'(s) > grp_max) grp_max = int'(s);
      if (int'(s) < grp_min) grp_min = int'(s);
      grp_count++;
      if (grp_count < tmswm_pkg::SAMPLES) return 1'b0;
      avg = (grp_sum - grp_min - grp_max) / (tmswm_pkg::SAMPLES - 2);
      grp_count = 0;
      grp_sum   = 0;
      grp_min   = 1023;
      grp_max   = 0;
      // Temperature is avg*500, current avg*50-25600, both in 1/1024 units
      if (k == 1'b0) begin
         val = avg * 500;
         flo = t_fault_lo; fhi = t_fault_hi; wlo = t_warn_lo; whi = t_warn_hi;
      end else begin
         val = avg * 50 - 25600;
         flo = c_fault_lo; fhi = c_fault_hi; wlo = c_warn_lo; whi = c_warn_hi;
      end
      if (val < flo || val > fhi) begin
         relay_latch    = 1'b1;
         critical_latch = 1'b1;
         warning_latch  = 1'b1;
         res.status     = tmswm_pkg::STATUS_FAULT;
      end else if (val <= wlo || val >= whi) begin
         warning_latch = 1'b1;
         res.status    = tmswm_pkg::STATUS_WARN;
      end else begin
         res.status = tmswm_pkg::STATUS_NORMAL;
      end
      res.channel  = ch;
      res.kind     = k;
      res.average  = tmswm_pkg::SAMPLE_W'(avg);
      res.scaled   = tmswm_pkg::SCALED_W'(val);
      res.relay    = relay_latch;
      res.critical = critical_latch;
      res.warning  = warning_latch;
      return 1'b1;
   endfunction

   // Present one sample, hold it through stalls, predict once accepted
   task automatic send_sample(input logic [tmswm_pkg::SAMPLE_W-1:0] s, input logic k,
         input logic [tmswm_pkg::CHANNEL_W-1:0] ch, input logic typed,
         input mean_result_type typed_res);
      mean_result_type res;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= s;
      req_kind    <= k;
      req_channel <= ch;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (predict_window(s, k, ch, res))
         pending_means.push_back(typed ? typed_res : res);
   endtask

   // Write one register; the caller drops csr_valid after the last write
   task automatic csr_write(input logic [tmswm_pkg::CSR_INDEX_W-1:0] idx,
         input logic [tmswm_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         tmswm_pkg::REG_TEMP_FAULT_LOW:  t_fault_lo = int'(data);
         tmswm_pkg::REG_TEMP_FAULT_HIGH: t_fault_hi = int'(data);
         tmswm_pkg::REG_TEMP_WARN_LOW:   t_warn_lo  = int'(data);
         tmswm_pkg::REG_TEMP_WARN_HIGH:  t_warn_hi  = int'(data);
         tmswm_pkg::REG_CURR_FAULT_LOW:  c_fault_lo = int'($signed(data[15:0]));
         tmswm_pkg::REG_CURR_FAULT_HIGH: c_fault_hi = int'($signed(data[15:0]));
         tmswm_pkg::REG_CURR_WARN_LOW:   c_warn_lo  = int'($signed(data[15:0]));
         tmswm_pkg::REG_CURR_WARN_HIGH:  c_warn_hi  = int'($signed(data[15:0]));
         default: ;
      endcase
   endtask

   // Hold the sender until every expected result is out, then let the pipe settle
   task automatic drain_results(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_means.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Program all eight windows for a phase: widest, nested, inverted, raw, extremes
   task automatic program_phase(input int p);
      int v[8];
      int tmp;
      bit raw;
      logic [tmswm_pkg::CSR_DATA_W-1:0] data;
      raw = 1'b0;
      v[0] = $urandom_range(0, 127875);
      v[2] = v[0] + $urandom_range(0, 127875);
      v[3] = 255750 + $urandom_range(0, 127875);
      v[1] = v[3] + $urandom_range(0, 127875);
      v[4] = -25600 + $urandom_range(0, 12787);
      v[6] = v[4] + $urandom_range(0, 12787);
      v[7] = -25 + $urandom_range(0, 12787);
      v[5] = v[7] + $urandom_range(0, 12787);
      case (p)
         0: v = '{0, 511500, 0, 511500, -25600, 25550, -25600, 25550};
         2: begin
            // swap every low with its high
            for (int i = 0; i < 8; i += 2) begin
               tmp = v[i]; v[i] = v[i+1]; v[i+1] = tmp;
            end
         end
         3, 7: raw = 1'b1;
         4: v = '{0, 0, 0, 0, -25600, -25600, -25600, -25600};
         5: v = '{511500, 511500, 511500, 511500, 25550, 25550, 25550, 25550};
         default: ;
      endcase
      for (int i = 0; i < 8; i++) begin
         if (raw)
            data = tmswm_pkg::CSR_DATA_W'($urandom);
         else if (i < 4)
            data = tmswm_pkg::CSR_DATA_W'(v[i]);
         else
            data = {3'($urandom_range(0, 7)), 16'(v[i])};
         csr_write(REG_ORDER[i], data);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string fname, input logic signed [31:0] want,
         input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
         fail_count++;
      end
   endtask

   // Receiver stalls at random
   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_means.size() == 0) begin
            $display("%0t: unexpected result, channel %0d kind %0d average %0d scaled %0d",
                     $time, rsp_channel_tag, rsp_kind_tag, rsp_average, rsp_scaled_value);
            fail_count++;
         end else begin
            head_mean = pending_means.pop_front();
            check_field("channel_tag", head_mean.channel, rsp_channel_tag);
            check_field("kind_tag", head_mean.kind, rsp_kind_tag);
            check_field("average", head_mean.average, rsp_average);
            check_field("scaled_value", $signed(head_mean.scaled), $signed(rsp_scaled_value));
            check_field("status", head_mean.status, rsp_status);
            check_field("relay_open", head_mean.relay, rsp_relay_open);
            check_field("critical_on", head_mean.critical, rsp_critical_on);
            check_field("warning_on", head_mean.warning, rsp_warning_on);
         end
      end
   end

   // Count cycles in which no handshake completes
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(posedge clock);
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("trimmed_mean_sensor_window_monitor verification failed");
      $finish;
   end

   initial begin
      int center, spread, s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table; raise the current fault floor between the two groups
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (r == 10) begin
            drain_results(8);
            // upper data bits are dropped, 16'h9C01 sign-extends to -25599
            csr_write(tmswm_pkg::REG_CURR_FAULT_LOW, 19'h59C01);
            csr_valid <= 1'b0;
         end
         send_sample(DIR_TABLE[r].sample, DIR_TABLE[r].kind, DIR_TABLE[r].chan,
                     DIR_TABLE[r].typed, DIR_TABLE[r].want);
      end

      // Random groups, each clustered around its own level
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results(8);
         gap_pct   = (phase < 3) ? 7 : (phase < 6) ? 58 : 0;
         stall_pct = (phase < 3) ? 58 : (phase < 6) ? 7 : 0;
         program_phase(phase);
         for (int g = 0; g < PHASE_GROUPS; g++) begin
            if (phase == 4 && g == 5) drain_results(0);
            center = $urandom_range(0, 1023);
            case ($urandom_range(0, 3))
               0: spread = 0;
               1: spread = 8;
               2: spread = 64;
               default: spread = 512;
            endcase
            for (int i = 0; i < tmswm_pkg::SAMPLES; i++) begin
               if ($urandom_range(0, 7) == 0)
                  s = $urandom_range(0, 1023);
               else
                  s = center - spread + $urandom_range(0, 2 * spread);
               if (s < 0) s = 0;
               if (s > 1023) s = 1023;
               send_sample(tmswm_pkg::SAMPLE_W'(s), 1'($urandom_range(0, 1)),
                           tmswm_pkg::CHANNEL_W'($urandom_range(0, 7)), 1'b0, NO_RES);
            end
         end
      end

      drain_results(12);
      if (fail_count == 0)
         $display("trimmed_mean_sensor_window_monitor verification clean");
      else
         $display("trimmed_mean_sensor_window_monitor verification failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/tmswm_pkg.sv
hdl/tmswm_front.sv
hdl/tmswm_queue.sv
hdl/tmswm_back.sv
hdl/trimmed_mean_sensor_window_monitor.sv
tb/sv/trimmed_mean_sensor_window_monitor_tb.sv
